### sv/bounded_length_max_subarray_top_macros.svh
// Assertion macros used by the checker file.
`ifndef BOUNDED_LENGTH_MAX_SUBARRAY_TOP_MACROS_SVH
`define BOUNDED_LENGTH_MAX_SUBARRAY_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BLMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blms check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BLMS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blms check failed");

`endif

### sv/blms_pkg.sv
package blms_pkg;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'd1;

    localparam logic [CFG_W-1:0] MIN_LEN_RESET = 9'd1;
    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 9'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_PC,
        ST_TAIL_RQ,
        ST_TAIL_Q,
        ST_TAIL_CMP,
        ST_PUSH,
        ST_HEAD_RQ,
        ST_HEAD_Q,
        ST_HEAD_V,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic ring_wr;
        logic ring_rd_c;
        logic pc_cap;
        logic q_rd_last;
        logic ring_rd_q;
        logic tail_pop;
        logic push;
        logic q_rd_head;
        logic head_pop;
        logic best_upd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic ovf;
        logic push_en;
        logic q_empty;
        logic tail_ge;
        logic head_old;
        logic out_free;
    } status_t;

endpackage

### sv/blms_in_if.sv
interface blms_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

### sv/blms_out_if.sv
interface blms_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [blms_pkg::OUT_W-1:0]    best_sum;
    logic                                 best_valid;
    logic                                 length_overflow;
    logic                                 array_done;

    modport source (output valid, output best_sum, output best_valid,
                    output length_overflow, output array_done, input ready);
    modport sink   (input valid, input best_sum, input best_valid,
                    input length_overflow, input array_done, output ready);
endinterface

### sv/blms_ctrl.sv
module blms_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  blms_pkg::status_t status,
    output blms_pkg::cmd_t    cmd
);

    blms_pkg::state_t state_reg;
    blms_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= blms_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            blms_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.ovf ? blms_pkg::ST_RESULT : blms_pkg::ST_WRITE;
                end
            end
            blms_pkg::ST_WRITE:
            begin
                cmd.ring_wr = 1'b1;
                if (status.push_en)
                begin
                    cmd.ring_rd_c = 1'b1;
                    state_next    = blms_pkg::ST_PC;
                end
                else
                begin
                    state_next = blms_pkg::ST_HEAD_RQ;
                end
            end
            blms_pkg::ST_PC:
            begin
                cmd.pc_cap = 1'b1;
                state_next = blms_pkg::ST_TAIL_RQ;
            end
            blms_pkg::ST_TAIL_RQ:
            begin
                if (status.q_empty)
                begin
                    state_next = blms_pkg::ST_PUSH;
                end
                else
                begin
                    cmd.q_rd_last = 1'b1;
                    state_next    = blms_pkg::ST_TAIL_Q;
                end
            end
            blms_pkg::ST_TAIL_Q:
            begin
                cmd.ring_rd_q = 1'b1;
                state_next    = blms_pkg::ST_TAIL_CMP;
            end
            blms_pkg::ST_TAIL_CMP:
            begin
                if (status.tail_ge)
                begin
                    cmd.tail_pop = 1'b1;
                    state_next   = blms_pkg::ST_TAIL_RQ;
                end
                else
                begin
                    state_next = blms_pkg::ST_PUSH;
                end
            end
            blms_pkg::ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = blms_pkg::ST_HEAD_RQ;
            end
            blms_pkg::ST_HEAD_RQ:
            begin
                if (status.q_empty)
                begin
                    state_next = blms_pkg::ST_RESULT;
                end
                else
                begin
                    cmd.q_rd_head = 1'b1;
                    state_next    = blms_pkg::ST_HEAD_Q;
                end
            end
            blms_pkg::ST_HEAD_Q:
            begin
                if (status.head_old)
                begin
                    cmd.head_pop = 1'b1;
                    state_next   = blms_pkg::ST_HEAD_RQ;
                end
                else
                begin
                    cmd.ring_rd_q = 1'b1;
                    state_next    = blms_pkg::ST_HEAD_V;
                end
            end
            blms_pkg::ST_HEAD_V:
            begin
                cmd.best_upd = 1'b1;
                state_next   = blms_pkg::ST_RESULT;
            end
            blms_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = blms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = blms_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/blms_dp.sv
module blms_dp #(
    parameter int MAX_WINDOW  = 256,
    parameter int MAX_LENGTH  = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [blms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [blms_pkg::CFG_W-1:0]          cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    input  logic                                last_sample,
    input  blms_pkg::cmd_t                      cmd,
    output blms_pkg::status_t                   status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [blms_pkg::OUT_W-1:0]   best_sum,
    output logic                                best_valid,
    output logic                                length_overflow,
    output logic                                array_done
);

    localparam int RING = MAX_WINDOW + 1;
    localparam int SW   = $clog2(RING);
    localparam int IW   = $clog2(MAX_LENGTH + 1);
    localparam int PW   = SAMPLE_BITS + $clog2(MAX_LENGTH) + 1;
    localparam int BW   = PW + 1;
    localparam int XW   = ((IW > SW) ? IW : SW) + 1;
    localparam int QW   = IW + SW;
    localparam int CW   = (BW > blms_pkg::OUT_W) ? BW : blms_pkg::OUT_W + 1;

    localparam logic [SW-1:0] SLOT_LAST = SW'(RING - 1);
    localparam logic signed [CW-1:0] SAT_HI = {{(CW - 23){1'b0}}, {23{1'b1}}};
    localparam logic signed [CW-1:0] SAT_LO = {{(CW - 23){1'b1}}, {23{1'b0}}};

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    // storage
    logic signed [PW-1:0] ring_mem [RING];
    logic [QW-1:0]        queue_mem [RING];

    // control and array state
    logic [blms_pkg::CFG_W-1:0] min_len_reg;
    logic [blms_pkg::CFG_W-1:0] max_len_reg;
    logic [IW-1:0]              count_reg;
    logic signed [PW-1:0]       prefix_reg;
    logic [SW-1:0]              wp_reg;
    logic                       ring0_reg;
    logic [SW-1:0]              head_reg;
    logic [SW-1:0]              tail_reg;
    logic signed [BW-1:0]       best_reg;
    logic                       flag_reg;
    logic                       out_valid_reg;

    // payload
    logic                       last_reg;
    logic                       ovf_reg;
    logic signed [PW-1:0]       pc_reg;
    logic signed [PW-1:0]       ring_q_reg;
    logic                       ring_zero_reg;
    logic [QW-1:0]              q_q_reg;
    logic signed [blms_pkg::OUT_W-1:0] out_sum_reg;
    logic                       out_bv_reg;
    logic                       out_ovf_reg;
    logic                       out_done_reg;

    logic [SW-1:0]        lo;
    logic [SW-1:0]        hi;
    logic                 len_ok;
    logic [XW-1:0]        c_wide;
    logic [SW-1:0]        cslot;
    logic [SW-1:0]        q_last;
    logic [SW-1:0]        q_len;
    logic                 q_full;
    logic [SW-1:0]        ring_raddr;
    logic signed [PW-1:0] ring_val;
    logic signed [BW-1:0] cand;
    logic signed [CW-1:0] best_ext;
    logic signed [blms_pkg::OUT_W-1:0] shown;

    // saturate the length registers to [1, MAX_WINDOW]
    always_comb
    begin
        if (min_len_reg == '0)
            lo = SW'(1);
        else if (32'(min_len_reg) > MAX_WINDOW)
            lo = SW'(MAX_WINDOW);
        else
            lo = SW'(min_len_reg);
        if (max_len_reg == '0)
            hi = SW'(1);
        else if (32'(max_len_reg) > MAX_WINDOW)
            hi = SW'(MAX_WINDOW);
        else
            hi = SW'(max_len_reg);
    end

    assign len_ok = (lo <= hi);
    assign c_wide = XW'(count_reg) - XW'(lo);
    assign cslot  = (wp_reg >= lo) ? wp_reg - lo : SW'(32'(wp_reg) + RING - 32'(lo));
    assign q_last = (tail_reg == '0) ? SLOT_LAST : tail_reg - 1'b1;
    assign q_len  = (tail_reg >= head_reg) ? tail_reg - head_reg
                                           : SW'(32'(tail_reg) + RING - 32'(head_reg));
    assign q_full = (q_len == SLOT_LAST);

    assign ring_raddr = cmd.ring_rd_c ? cslot : q_q_reg[SW-1:0];
    // slot 0 holds the empty prefix until it is overwritten in this array
    assign ring_val   = ring_zero_reg ? '0 : ring_q_reg;
    assign cand       = BW'(prefix_reg) - BW'(ring_val);

    assign status.ovf      = (count_reg >= IW'(MAX_LENGTH));
    assign status.push_en  = len_ok && (XW'(count_reg) >= XW'(lo));
    assign status.q_empty  = (head_reg == tail_reg);
    assign status.tail_ge  = (ring_val >= pc_reg);
    assign status.head_old = (XW'(q_q_reg[QW-1:SW]) + XW'(hi)) < XW'(count_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    assign best_ext = CW'(best_reg);
    always_comb
    begin
        if (!flag_reg)
            shown = '0;
        else if (best_ext > SAT_HI)
            shown = SAT_HI[blms_pkg::OUT_W-1:0];
        else if (best_ext < SAT_LO)
            shown = SAT_LO[blms_pkg::OUT_W-1:0];
        else
            shown = best_ext[blms_pkg::OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ring_wr)
        begin
            ring_mem[wp_reg] <= prefix_reg;
        end
        if (cmd.ring_rd_c || cmd.ring_rd_q)
        begin
            ring_q_reg <= ring_mem[ring_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            queue_mem[tail_reg] <= {c_wide[IW-1:0], cslot};
        end
        if (cmd.q_rd_last)
        begin
            q_q_reg <= queue_mem[q_last];
        end
        else if (cmd.q_rd_head)
        begin
            q_q_reg <= queue_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            last_reg <= last_sample;
            ovf_reg  <= status.ovf;
        end
        if (cmd.ring_rd_c || cmd.ring_rd_q)
        begin
            ring_zero_reg <= (ring_raddr == '0) && !ring0_reg;
        end
        if (cmd.pc_cap)
        begin
            pc_reg <= ring_val;
        end
        if (cmd.out_load)
        begin
            out_sum_reg  <= shown;
            out_bv_reg   <= flag_reg;
            out_ovf_reg  <= ovf_reg;
            out_done_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg   <= blms_pkg::MIN_LEN_RESET;
            max_len_reg   <= blms_pkg::MAX_LEN_RESET;
            count_reg     <= '0;
            prefix_reg    <= '0;
            wp_reg        <= '0;
            ring0_reg     <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            best_reg      <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    blms_pkg::REG_MIN_LEN: min_len_reg <= cfg_data;
                    blms_pkg::REG_MAX_LEN: max_len_reg <= cfg_data;
                endcase
            end
            if (cmd.accept && !status.ovf)
            begin
                count_reg  <= count_reg + 1'b1;
                prefix_reg <= prefix_reg + PW'(sample);
                wp_reg     <= slot_inc(wp_reg);
            end
            if (cmd.ring_wr && wp_reg == '0)
            begin
                ring0_reg <= 1'b1;
            end
            if (cmd.tail_pop)
            begin
                tail_reg <= q_last;
            end
            if (cmd.push)
            begin
                tail_reg <= slot_inc(tail_reg);
                // full queue drops its oldest entry
                if (q_full)
                begin
                    head_reg <= slot_inc(head_reg);
                end
            end
            if (cmd.head_pop)
            begin
                head_reg <= slot_inc(head_reg);
            end
            if (cmd.best_upd && len_ok && (!flag_reg || cand > best_reg))
            begin
                best_reg <= cand;
                flag_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    count_reg  <= '0;
                    prefix_reg <= '0;
                    wp_reg     <= '0;
                    ring0_reg  <= 1'b0;
                    head_reg   <= '0;
                    tail_reg   <= '0;
                    best_reg   <= '0;
                    flag_reg   <= 1'b0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign best_sum        = out_sum_reg;
    assign best_valid      = out_bv_reg;
    assign length_overflow = out_ovf_reg;
    assign array_done      = out_done_reg;

endmodule

### sv/bounded_length_max_subarray_top.sv
// channel  dir  handshake          payload
// in_ch    in   valid / ready      sample, last_sample
// out_ch   out  valid / ready      best_sum, best_valid, length_overflow, array_done
// cfg      in   cfg_we (no ready)  cfg_index, cfg_data
//
// An accepted item writes its prefix to the ring; at or past the minimum length it reads the
// candidate prefix, pops tail entries whose prefix is not below it and pushes the candidate;
// it then drops expired head entries and checks the oldest start against the best sum; the
// ring's single read port is shared by the candidate read, tail compare and head lookup.
// A sample past MAX_LENGTH skips to the result. rst_n clears all array state at once.
// The result sits in an output register; only a second result ready before the first is
// taken stalls the block.
module bounded_length_max_subarray_top #(
    parameter int MAX_WINDOW  = 256,
    parameter int MAX_LENGTH  = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    blms_in_if.sink                        in_ch,
    blms_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [blms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [blms_pkg::CFG_W-1:0]     cfg_data
);

    blms_pkg::cmd_t    cmd;
    blms_pkg::status_t status;

    blms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    blms_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_LENGTH  (MAX_LENGTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample          (in_ch.sample),
        .last_sample     (in_ch.last_sample),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .best_sum        (out_ch.best_sum),
        .best_valid      (out_ch.best_valid),
        .length_overflow (out_ch.length_overflow),
        .array_done      (out_ch.array_done)
    );

endmodule

### sv/blms_checker.sv
`include "bounded_length_max_subarray_top_macros.svh"

module blms_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [blms_pkg::OUT_W-1:0] best_sum,
    input logic                              best_valid
);

    // a stalled result stays put
    `BLMS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(best_sum))

    // no qualifying run yet means a zero sum
    `BLMS_ASSERT_IMP(a_zero_invalid, out_valid && !best_valid, best_sum == '0)

    // one item at a time: ready drops right after an item is taken
    `BLMS_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)

endmodule

bind bounded_length_max_subarray_top blms_checker u_blms_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .best_sum   (out_ch.best_sum),
    .best_valid (out_ch.best_valid)
);
